@@ src/rob_pkg.sv @@
// Shared types and constants for the in-order reorder buffer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package rob_pkg;

	localparam int ROB_DEPTH        = 32;
	localparam int ROB_RETIRE_WIDTH = 4;

	localparam int FUNC_W  = 2;
	localparam int TAG_W   = 32;
	localparam int RTYPE_W = 2;
	localparam int RCNT_W  = 3;
	localparam int OCC_W   = 6;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC  = 2'd0,
		FUNC_COMMIT = 2'd1,
		FUNC_TICK   = 2'd2
	} func_t;

	localparam logic [RTYPE_W-1:0] REQ_COMPUTE = 2'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RETIRE
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic             shift;
		logic             alloc;
		logic             alloc_rdy;
		logic             search_start;
		logic [TAG_W-1:0] tag;
	} cell_ctrl_t;

	// What one cell holds and shows to its neighbors.
	typedef struct packed {
		logic             valid;
		logic             rdy;
		logic [TAG_W-1:0] tag;
	} cell_data_t;

endpackage

`default_nettype wire

@@ src/rob_req_if.sv @@
// Request channel of the reorder buffer: valid/ready handshake and one operation.
// Depends on rob_pkg for the field widths.
`default_nettype none

interface rob_req_if;
	logic                         valid;
	logic                         ready;
	logic [rob_pkg::FUNC_W-1:0]   func;
	logic [rob_pkg::TAG_W-1:0]    msg_id;
	logic [rob_pkg::RTYPE_W-1:0]  req_type;

	modport source (output valid, output func, output msg_id, output req_type, input ready);
	modport sink   (input valid, input func, input msg_id, input req_type, output ready);
endinterface

`default_nettype wire

@@ src/rob_rsp_if.sv @@
// Response channel of the reorder buffer: valid/ready handshake and one result.
// Depends on rob_pkg for the field widths.
`default_nettype none

interface rob_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        op_ok;
	logic [rob_pkg::RCNT_W-1:0]  retired_count;
	logic [rob_pkg::OCC_W-1:0]   occupancy;

	modport source (output valid, output op_ok, output retired_count, output occupancy,
		input ready);
	modport sink   (input valid, input op_ok, input retired_count, input occupancy,
		output ready);
endinterface

`default_nettype wire

@@ src/rob_cell.sv @@
// One slot of the reorder buffer chain: entry state plus the search token.
// Depends on rob_pkg for the control and data structs.
`default_nettype none

module rob_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rob_pkg::cell_ctrl_t ctrl,
	input  logic                prev_valid,
	input  rob_pkg::cell_data_t nxt,
	input  logic                tok_in,
	output rob_pkg::cell_data_t data,
	output logic                tok_out,
	output logic                hit
);
	import rob_pkg::*;

	logic             valid_q;
	logic             rdy_q;
	logic             tok_q;
	logic [TAG_W-1:0] tag_q;
	logic             take_alloc;
	logic             match;

	// The first empty slot behind a valid one takes a new entry.
	assign take_alloc = ctrl.alloc & ~valid_q & prev_valid;
	assign match      = (tag_q == ctrl.tag);
	assign hit        = tok_q & valid_q & match;
	// The token moves on only past a valid slot that does not match.
	assign tok_out    = tok_q & valid_q & ~match;

	assign data.valid = valid_q;
	assign data.rdy   = rdy_q;
	assign data.tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rdy_q   <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			priority if (ctrl.shift) begin
				valid_q <= nxt.valid;
				rdy_q   <= nxt.rdy;
			end else if (take_alloc) begin
				valid_q <= 1'b1;
				rdy_q   <= ctrl.alloc_rdy;
			end else if (hit) begin
				rdy_q <= 1'b1;
			end else begin
				rdy_q <= rdy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.shift) begin
			tag_q <= nxt.tag;
		end else if (take_alloc) begin
			tag_q <= ctrl.tag;
		end else begin
			tag_q <= tag_q;
		end
	end

endmodule

`default_nettype wire

@@ src/reorder_buffer_inorder_retire_unit.sv @@
// Top level of the in-order reorder buffer: controller and the row of cells.
// Depends on rob_pkg, rob_req_if, rob_rsp_if and rob_cell.
`default_nettype none

// The buffer is a row of DEPTH cells with the oldest entry in cell 0; retiring
// shifts the whole row one cell toward the head per cycle. An allocate or an
// unknown operation is answered at the edge that accepts it. A commit sends a
// search token down the row one cell per cycle; its result is loaded when the
// token reaches the oldest matching entry, or the first empty cell on a miss.
// A tick retires ready entries from the head, up to RETIRE_WIDTH of them, and
// then loads its result. A new operation is taken once the previous one has
// finished and the result register is free or being read; the result register
// is the only output stage.
module reorder_buffer_inorder_retire_unit #(
	parameter int DEPTH        = rob_pkg::ROB_DEPTH,
	parameter int RETIRE_WIDTH = rob_pkg::ROB_RETIRE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rob_req_if.sink   req,
	rob_rsp_if.source rsp
);
	import rob_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $clog2(RETIRE_WIDTH + 1);

	state_t           state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [RW-1:0]    ret_q, ret_d;
	logic [TAG_W-1:0] tag_q;
	logic             out_valid_q;
	logic             out_ok_q;
	logic [RCNT_W-1:0] out_ret_q;
	logic [OCC_W-1:0] out_occ_q;

	logic             out_free;
	logic             acc;
	logic             load_out;
	logic             res_ok;
	logic [RW-1:0]    res_ret;
	logic [CW-1:0]    res_occ;
	logic             hit_any;

	cell_ctrl_t       ctrl;
	cell_data_t       cd [DEPTH];
	logic [DEPTH-1:0] tok_nxt;
	logic [DEPTH-1:0] hit_vec;
	logic [DEPTH-1:0] valid_vec;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic       prev_valid;
			cell_data_t nxt;
			logic       tok_in;

			if (gi == 0) begin : g_head
				assign prev_valid = 1'b1;
				assign tok_in     = ctrl.search_start;
			end else begin : g_body
				assign prev_valid = cd[gi-1].valid;
				assign tok_in     = tok_nxt[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = cd[gi+1];
			end

			rob_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_valid (prev_valid),
				.nxt        (nxt),
				.tok_in     (tok_in),
				.data       (cd[gi]),
				.tok_out    (tok_nxt[gi]),
				.hit        (hit_vec[gi])
			);

			assign valid_vec[gi] = cd[gi].valid;
		end
	endgenerate

	assign hit_any   = |hit_vec;
	assign out_free  = ~out_valid_q | rsp.ready;
	assign req.ready = (state_q == ST_IDLE) & out_free;
	assign acc       = req.valid & req.ready;

	always_comb begin
		state_d           = state_q;
		cnt_d             = cnt_q;
		pos_d             = pos_q;
		ret_d             = ret_q;
		load_out          = 1'b0;
		res_ok            = 1'b0;
		res_ret           = '0;
		res_occ           = cnt_q;
		ctrl.shift        = 1'b0;
		ctrl.alloc        = 1'b0;
		ctrl.alloc_rdy    = (req.req_type == REQ_COMPUTE);
		ctrl.search_start = 1'b0;
		ctrl.tag          = (state_q == ST_IDLE) ? req.msg_id : tag_q;

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					priority if (req.func == FUNC_ALLOC) begin
						load_out = 1'b1;
						if (cnt_q != CW'(DEPTH)) begin
							ctrl.alloc = 1'b1;
							cnt_d      = cnt_q + 1'b1;
							res_ok     = 1'b1;
							res_occ    = cnt_q + 1'b1;
						end
					end else if (req.func == FUNC_COMMIT) begin
						ctrl.search_start = 1'b1;
						pos_d             = '0;
						state_d           = ST_SEARCH;
					end else if (req.func == FUNC_TICK) begin
						ret_d   = '0;
						state_d = ST_RETIRE;
					end else begin
						load_out = 1'b1;
					end
				end
			end
			ST_SEARCH: begin
				// The token sits in cell pos_q; reaching the first empty cell means a miss.
				if (hit_any || pos_q == cnt_q) begin
					load_out = 1'b1;
					res_ok   = hit_any;
					state_d  = ST_IDLE;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			ST_RETIRE: begin
				if (cd[0].valid && cd[0].rdy && ret_q != RW'(RETIRE_WIDTH)) begin
					ctrl.shift = 1'b1;
					cnt_d      = cnt_q - 1'b1;
					ret_d      = ret_q + 1'b1;
				end else begin
					load_out = 1'b1;
					res_ok   = 1'b1;
					res_ret  = ret_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			ret_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			ret_q   <= ret_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tag_q <= req.msg_id;
		end
		if (load_out) begin
			out_ok_q  <= res_ok;
			out_ret_q <= RCNT_W'(res_ret);
			out_occ_q <= OCC_W'(res_occ);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.op_ok         = out_ok_q;
	assign rsp.retired_count = out_ret_q;
	assign rsp.occupancy     = out_occ_q;

`ifndef NO_ASSERTIONS
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(valid_vec)))
		else $error("entry count disagrees with valid cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid cells are not packed toward the head");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_nxt))
		else $error("more than one search token in flight");

	a_token_exit_full: assert property (@(posedge clk) disable iff (!arst_n)
		tok_nxt[DEPTH-1] |-> (cnt_q == CW'(DEPTH) && pos_q == CW'(DEPTH - 1)))
		else $error("search token left the row while the buffer was not full");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !rsp.valid)
		else $error("result pending while an operation is in progress");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the in-order reorder buffer: allocate, commit, tick, unknown ops.
// Depends on rob_pkg, rob_req_if, rob_rsp_if and reorder_buffer_inorder_retire_unit.
// A cycle-free model of the buffer predicts every result word, which is checked in order.
module testbench;
	import rob_pkg::*;

	localparam int ROB_SLOTS     = ROB_DEPTH;
	localparam int RETIRE_MAX    = ROB_RETIRE_WIDTH;
	localparam int RANDOM_OPS    = 1400;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 64;

	localparam logic [FUNC_W-1:0]  FUNC_UNKNOWN = 2'd3;
	localparam logic [RTYPE_W-1:0] REQ_LOAD     = 2'd1;
	localparam logic [RTYPE_W-1:0] REQ_STORE    = 2'd2;
	localparam logic [RTYPE_W-1:0] REQ_UNKNOWN  = 2'd3;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_FLAT} op_mix_t;
	typedef enum int {RX_ALWAYS, RX_RHYTHM, RX_COIN, RX_LONG} rx_mode_t;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [TAG_W-1:0]   msg_id;
		logic [RTYPE_W-1:0] req_type;
		bit                 drain;    // hold this word until every result is back
	} rob_op_t;

	typedef struct {
		logic              op_ok;
		logic [RCNT_W-1:0] retired_count;
		logic [OCC_W-1:0]  occupancy;
	} rob_result_t;

	logic clk;
	logic arst_n;

	rob_req_if req_ch ();
	rob_rsp_if rsp_ch ();

	reorder_buffer_inorder_retire_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the buffer contents.
	logic [TAG_W-1:0] shadow_tag [ROB_SLOTS];
	logic             shadow_rdy [ROB_SLOTS];
	int               shadow_head  = 0;
	int               shadow_tail  = 0;
	int               shadow_count = 0;

	rob_op_t     pending_ops [$];
	rob_result_t result_q [$];
	rob_op_t     cur_op;

	int sent_count  = 0;
	int recv_count  = 0;
	int err_count   = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	int gap_left    = 0;
	int stall_age   = 0;
	int stall_left  = 0;
	int rhythm      = 0;
	rx_mode_t stall_mode = RX_ALWAYS;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rob_result_t rob_apply(rob_op_t op);
		rob_result_t r;
		int          p;
		int          i;
		int          n;
		bit          found;
		r.op_ok = 1'b0;
		n = 0;
		case (op.func)
			FUNC_ALLOC: begin
				if (shadow_count < ROB_SLOTS) begin
					shadow_tag[shadow_tail] = op.msg_id;
					shadow_rdy[shadow_tail] = (op.req_type == REQ_COMPUTE);
					shadow_tail = (shadow_tail + 1) % ROB_SLOTS;
					shadow_count++;
					r.op_ok = 1'b1;
				end
			end
			FUNC_COMMIT: begin
				// Only the oldest matching entry is marked.
				p = shadow_head;
				found = 1'b0;
				for (i = 0; i < shadow_count; i++) begin
					if (!found && shadow_tag[p] == op.msg_id) begin
						shadow_rdy[p] = 1'b1;
						found = 1'b1;
					end
					p = (p + 1) % ROB_SLOTS;
				end
				r.op_ok = found;
			end
			FUNC_TICK: begin
				r.op_ok = 1'b1;
				while (shadow_count > 0 && n < RETIRE_MAX && shadow_rdy[shadow_head]) begin
					shadow_rdy[shadow_head] = 1'b0;
					shadow_head = (shadow_head + 1) % ROB_SLOTS;
					shadow_count--;
					n++;
				end
			end
			default: ;
		endcase
		r.retired_count = RCNT_W'(n);
		r.occupancy     = OCC_W'(shadow_count);
		return r;
	endfunction

	function automatic void add_op(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tag,
			logic [RTYPE_W-1:0] rtype, bit drain);
		rob_op_t op;
		op.func     = func;
		op.msg_id   = tag;
		op.req_type = rtype;
		op.drain    = drain;
		pending_ops = {pending_ops, op};
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// Request driver: bursts of words separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic hold;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			hold = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				result_q = {result_q, rob_apply(cur_op)};
				sent_count++;
				hold = 1'b0;
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0 &&
						(!pending_ops[0].drain || sent_count == recv_count)) begin
					cur_op = pending_ops.pop_front();
					req_ch.func     <= cur_op.func;
					req_ch.msg_id   <= cur_op.msg_id;
					req_ch.req_type <= cur_op.req_type;
					hold = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			req_ch.valid <= hold;
		end
	end

	// Response sink: the stall style is picked at random and changed at random intervals.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (stall_age == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				stall_age  = $urandom_range(100, 400);
			end
			stall_age--;
			rhythm = (rhythm + 1) % 3;
			case (stall_mode)
				RX_ALWAYS: rsp_ch.ready <= 1'b1;
				RX_RHYTHM: rsp_ch.ready <= (rhythm == 0);
				RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rsp_ch.ready <= 1'b0;
					end else begin
						rsp_ch.ready <= 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(4, 24);
					end
				end
			endcase
		end
	end

	// Result checker and watchdog.
	always @(posedge clk or negedge arst_n) begin
		rob_result_t want;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				recv_count <= recv_count + 1;
				if (result_q.size() == 0) begin
					report_mismatch("result word with no operation outstanding");
				end else begin
					want = result_q.pop_front();
					if (rsp_ch.op_ok !== want.op_ok)
						report_mismatch($sformatf("op_ok %b, expected %b",
							rsp_ch.op_ok, want.op_ok));
					if (rsp_ch.retired_count !== want.retired_count)
						report_mismatch($sformatf("retired_count %0d, expected %0d",
							rsp_ch.retired_count, want.retired_count));
					if (rsp_ch.occupancy !== want.occupancy)
						report_mismatch($sformatf("occupancy %0d, expected %0d",
							rsp_ch.occupancy, want.occupancy));
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [TAG_W-1:0]   tag_pool [16];
		logic [FUNC_W-1:0]  func;
		logic [TAG_W-1:0]   tag;
		logic [RTYPE_W-1:0] rtype;
		op_mix_t            mix;
		int                 alloc_pct;
		int                 commit_pct;
		int                 tick_pct;
		int                 run_len;
		int                 pick;
		int                 n;
		int                 k;
		bit                 first;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = FUNC_ALLOC;
		req_ch.msg_id   = '0;
		req_ch.req_type = REQ_COMPUTE;
		rsp_ch.ready    = 1'b0;

		// Directed opening: empty buffer, every request type, duplicate tags,
		// commit misses and repeats, an unknown operation and a capped retire.
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'h1234_5678, REQ_COMPUTE, 1'b0);
		add_op(FUNC_ALLOC,   32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_ALLOC,   32'hFFFF_FFFF, REQ_LOAD,    1'b0);
		add_op(FUNC_ALLOC,   32'hA5A5_A5A5, REQ_STORE,   1'b0);
		add_op(FUNC_ALLOC,   32'h5A5A_5A5A, REQ_UNKNOWN, 1'b0);
		add_op(FUNC_ALLOC,   32'hFFFF_FFFF, REQ_LOAD,    1'b0);
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'h1234_5678, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'hFFFF_FFFF, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'hFFFF_FFFF, REQ_COMPUTE, 1'b0);
		add_op(FUNC_UNKNOWN, 32'hFFFF_FFFF, REQ_UNKNOWN, 1'b0);
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'hA5A5_A5A5, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'h5A5A_5A5A, REQ_COMPUTE, 1'b0);
		add_op(FUNC_COMMIT,  32'hFFFF_FFFF, REQ_COMPUTE, 1'b0);
		for (k = 0; k < 5; k++)
			add_op(FUNC_ALLOC, TAG_W'(k + 1), REQ_COMPUTE, 1'b0);
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);
		add_op(FUNC_TICK,    32'h0000_0000, REQ_COMPUTE, 1'b0);

		// Small tag pool so commits usually hit and duplicates are common.
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (k = 2; k < 16; k++)
			tag_pool[k] = $urandom;

		// Random runs pick among filling, draining, balanced and flat mixes.
		n = 0;
		first = 1'b1;
		while (n < RANDOM_OPS) begin
			mix = op_mix_t'($urandom_range(0, 3));
			run_len = $urandom_range(20, 90);
			case (mix)
				MIX_BALANCED: begin alloc_pct = 40; commit_pct = 35; tick_pct = 22; end
				MIX_FILL:     begin alloc_pct = 75; commit_pct = 15; tick_pct = 8;  end
				MIX_DRAIN:    begin alloc_pct = 15; commit_pct = 40; tick_pct = 43; end
				default:      begin alloc_pct = 30; commit_pct = 30; tick_pct = 30; end
			endcase
			for (k = 0; k < run_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < alloc_pct)
					func = FUNC_ALLOC;
				else if (pick < alloc_pct + commit_pct)
					func = FUNC_COMMIT;
				else if (pick < alloc_pct + commit_pct + tick_pct)
					func = FUNC_TICK;
				else
					func = FUNC_UNKNOWN;
				tag = ($urandom_range(0, 3) == 0) ? $urandom : tag_pool[$urandom_range(0, 15)];
				pick = $urandom_range(0, 9);
				if (pick < 4)
					rtype = REQ_COMPUTE;
				else if (pick < 6)
					rtype = REQ_LOAD;
				else if (pick < 8)
					rtype = REQ_STORE;
				else
					rtype = REQ_UNKNOWN;
				add_op(func, tag, rtype, first || ($urandom_range(0, 199) == 0));
				first = 1'b0;
				if (func != FUNC_UNKNOWN)
					n++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/rob_pkg.sv
src/rob_req_if.sv
src/rob_rsp_if.sv
src/rob_cell.sv
src/reorder_buffer_inorder_retire_unit.sv
tb/sv/testbench.sv
